@@ rtl/lsoa_pkg.sv @@
// shared types and constants for the laser scan obstacle avoidance block
package lsoa_pkg;

  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned AVOID_RUN   = 10;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned NS_W    = 11;
  localparam int unsigned IDX_W   = $clog2(MAX_SAMPLES);
  localparam int unsigned N_W     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CMP_W   = (NS_W > N_W) ? NS_W : N_W;
  localparam int unsigned CNT_W   = 9;

  // reciprocal for draw / AVOID_RUN, exact over all 16-bit draws for AVOID_RUN <= 255
  localparam int unsigned DIV_SHIFT = 24;
  localparam longint unsigned DIV_RECIP = ((64'd1 << DIV_SHIFT) + AVOID_RUN - 1) / AVOID_RUN;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = RANGE_W + RECIP_W;

  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register indexes (word address)
  localparam logic [1:0] REG_NUM_SAMPLES = 2'd0;
  localparam logic [1:0] REG_FRONT_THR   = 2'd1;
  localparam logic [1:0] REG_STOP_THR    = 2'd2;

  localparam logic [NS_W-1:0]    NUM_SAMPLES_RST = NS_W'(360);
  localparam logic [RANGE_W-1:0] FRONT_THR_RST   = RANGE_W'(600);
  localparam logic [RANGE_W-1:0] STOP_THR_RST    = RANGE_W'(500);

  typedef struct packed {
    logic [NS_W-1:0]    num_samples;
    logic [RANGE_W-1:0] front_threshold_mm;
    logic [RANGE_W-1:0] stop_threshold_mm;
  } cfg_t;

endpackage

@@ rtl/lsoa_regs.sv @@
// apb configuration registers for the obstacle avoidance block
module lsoa_regs
  import lsoa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_NUM_SAMPLES: cfg_nxt.num_samples        = pwdata[NS_W-1:0];
        REG_FRONT_THR:   cfg_nxt.front_threshold_mm = pwdata[RANGE_W-1:0];
        REG_STOP_THR:    cfg_nxt.stop_threshold_mm  = pwdata[RANGE_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_samples        <= NUM_SAMPLES_RST;
      cfg_r.front_threshold_mm <= FRONT_THR_RST;
      cfg_r.stop_threshold_mm  <= STOP_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NUM_SAMPLES: prdata = DATA_W'(cfg_r.num_samples);
      REG_FRONT_THR:   prdata = DATA_W'(cfg_r.front_threshold_mm);
      REG_STOP_THR:    prdata = DATA_W'(cfg_r.stop_threshold_mm);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/laser_scan_obstacle_avoid_top.sv @@
// top level: per-sample scan tracking and end-of-scan avoidance decision
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in_     | in        | in_valid / in_stall  | range_mm, rand_draw
//  out_    | out       | out_valid / out_stall| avoiding, stop_now, new_turn,
//          |           |                     | turn_positive, min_left_mm, min_right_mm
//  apb     | in/out    | psel/penable/pready | num_samples, front/stop thresholds
//
// one item per cycle sustained while no scan-ending item waits on a full, stalled result
// register; an accepted item is held in the input register, which updates the scan state
// and, for the last sample of a scan, the result register that drives the outputs
// synchronous active-low reset clears the scan state, avoid count and turn sign
// an out_stall only blocks the input when the item in the input register ends a scan
// and the result register is still full; other samples keep flowing
module laser_scan_obstacle_avoid_top
  import lsoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // sample input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RANGE_W-1:0] in_range_mm,
  input  logic [RANGE_W-1:0] in_rand_draw,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_avoiding,
  output logic               out_stop_now,
  output logic               out_new_turn,
  output logic               out_turn_positive,
  output logic [RANGE_W-1:0] out_min_left_mm,
  output logic [RANGE_W-1:0] out_min_right_mm,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;

  lsoa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic               s1_vld_r, s1_vld_nxt;
  logic [RANGE_W-1:0] s1_range_r;
  logic [RANGE_W-1:0] s1_draw_r;

  // scan state
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [RANGE_W-1:0] lmin_r, lmin_nxt;
  logic [RANGE_W-1:0] rmin_r, rmin_nxt;
  logic               front_r, front_nxt;
  logic               stop_r, stop_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               sign_r, sign_nxt;

  // result register
  logic               ovld_r, ovld_nxt;
  logic               o_avoid_r, o_stop_r, o_new_r, o_sign_r;
  logic [RANGE_W-1:0] o_lmin_r, o_rmin_r;

  // clamped scan length and window bounds
  logic [CMP_W-1:0]   ns_ext;
  logic [N_W-1:0]     n_len;
  logic [N_W-1:0]     quarter;
  logic [N_W-1:0]     half;
  logic [N_W-1:0]     i_ext;
  logic               last;
  logic               proc;
  logic               in_acc;

  // per-sample results including the current sample
  logic               front_hit, stop_hit, left_side;
  logic [RANGE_W-1:0] lmin_cur, rmin_cur;

  // end-of-scan avoid decision
  logic [PROD_W-1:0]  draw_prod;
  logic [RANGE_W-1:0] draw_quot;
  logic [RANGE_W-1:0] draw_rem;
  logic [CNT_W-1:0]   cnt_load;
  logic [CNT_W-1:0]   cnt_base;
  logic               avoid;
  logic               fresh;
  logic               sign_new;

  always_comb begin
    ns_ext = CMP_W'(cfg.num_samples);
    if (ns_ext == '0) begin
      n_len = N_W'(1);
    end else if (ns_ext > CMP_W'(MAX_SAMPLES)) begin
      n_len = N_W'(MAX_SAMPLES);
    end else begin
      n_len = N_W'(ns_ext);
    end
  end

  assign quarter = n_len >> 2;
  assign half    = n_len >> 1;
  assign i_ext   = N_W'(idx_r);

  // also ends the scan when the length was shrunk below the current index
  assign last = !((i_ext + N_W'(1)) < n_len);

  // a scan-ending item needs the result register free
  assign proc     = s1_vld_r && (!last || !ovld_r || !out_stall);
  assign in_stall = s1_vld_r && !proc;
  assign in_acc   = in_valid && !in_stall;

  assign front_hit = (i_ext > quarter) && (i_ext < (n_len - quarter))
                     && (s1_range_r < cfg.front_threshold_mm);
  assign stop_hit  = s1_range_r < cfg.stop_threshold_mm;
  assign left_side = i_ext > half;

  always_comb begin
    lmin_cur = lmin_r;
    rmin_cur = rmin_r;
    if (left_side) begin
      if (s1_range_r < lmin_r) lmin_cur = s1_range_r;
    end else begin
      if (s1_range_r < rmin_r) rmin_cur = s1_range_r;
    end
  end

  // draw mod AVOID_RUN through a reciprocal multiply
  assign draw_prod = PROD_W'(s1_draw_r) * PROD_W'(DIV_RECIP);
  assign draw_quot = draw_prod[DIV_SHIFT +: RANGE_W];
  assign draw_rem  = s1_draw_r - RANGE_W'(draw_quot * RANGE_W'(AVOID_RUN));
  assign cnt_load  = CNT_W'(draw_rem) + CNT_W'(AVOID_RUN);

  assign avoid    = front_r || front_hit || stop_r || stop_hit || (cnt_r != '0);
  assign fresh    = avoid && (cnt_r == '0);
  assign sign_new = !(lmin_cur < rmin_cur);
  assign cnt_base = fresh ? cnt_load : cnt_r;

  always_comb begin
    idx_nxt   = idx_r;
    lmin_nxt  = lmin_r;
    rmin_nxt  = rmin_r;
    front_nxt = front_r;
    stop_nxt  = stop_r;
    cnt_nxt   = cnt_r;
    sign_nxt  = sign_r;
    if (proc) begin
      if (!last) begin
        idx_nxt   = IDX_W'(i_ext + N_W'(1));
        lmin_nxt  = lmin_cur;
        rmin_nxt  = rmin_cur;
        front_nxt = front_r || front_hit;
        stop_nxt  = stop_r || stop_hit;
      end else begin
        // start the next scan clean
        idx_nxt   = '0;
        lmin_nxt  = RANGE_MAX;
        rmin_nxt  = RANGE_MAX;
        front_nxt = 1'b0;
        stop_nxt  = 1'b0;
        if (avoid) begin
          cnt_nxt = cnt_base - CNT_W'(1);
        end
        if (fresh) begin
          sign_nxt = sign_new;
        end
      end
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (proc) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (proc && last) begin
      ovld_nxt = 1'b1;
    end else if (!out_stall) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      ovld_r   <= 1'b0;
      idx_r    <= '0;
      lmin_r   <= RANGE_MAX;
      rmin_r   <= RANGE_MAX;
      front_r  <= 1'b0;
      stop_r   <= 1'b0;
      cnt_r    <= '0;
      sign_r   <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      ovld_r   <= ovld_nxt;
      idx_r    <= idx_nxt;
      lmin_r   <= lmin_nxt;
      rmin_r   <= rmin_nxt;
      front_r  <= front_nxt;
      stop_r   <= stop_nxt;
      cnt_r    <= cnt_nxt;
      sign_r   <= sign_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_range_r <= in_range_mm;
      s1_draw_r  <= in_rand_draw;
    end
    if (proc && last) begin
      o_avoid_r <= avoid;
      o_stop_r  <= stop_r || stop_hit;
      o_new_r   <= fresh;
      o_sign_r  <= fresh ? sign_new : sign_r;
      o_lmin_r  <= lmin_cur;
      o_rmin_r  <= rmin_cur;
    end
  end

  assign out_valid         = ovld_r;
  assign out_avoiding      = o_avoid_r;
  assign out_stop_now      = o_stop_r;
  assign out_new_turn      = o_new_r;
  assign out_turn_positive = o_sign_r;
  assign out_min_left_mm   = o_lmin_r;
  assign out_min_right_mm  = o_rmin_r;

endmodule

@@ tb/sv/lsoa_scan_checker.sv @@
// scan checker: predicts end-of-scan avoidance results and compares them with the block
module lsoa_scan_checker
  import lsoa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [RANGE_W-1:0] in_range_mm,
  input  logic [RANGE_W-1:0] in_rand_draw,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_avoiding,
  input  logic               out_stop_now,
  input  logic               out_new_turn,
  input  logic               out_turn_positive,
  input  logic [RANGE_W-1:0] out_min_left_mm,
  input  logic [RANGE_W-1:0] out_min_right_mm,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int                 mismatches,
  output int                 pending_results,
  output int                 results_checked
);

  typedef struct packed {
    logic               avoiding;
    logic               stop_now;
    logic               new_turn;
    logic               turn_positive;
    logic [RANGE_W-1:0] min_left;
    logic [RANGE_W-1:0] min_right;
  } avoid_result_t;

  avoid_result_t      expected_results[$];
  cfg_t               cfg;
  int unsigned        scan_pos;
  logic [RANGE_W-1:0] left_min;
  logic [RANGE_W-1:0] right_min;
  logic               front_hit;
  logic               stop_hit;
  logic [CNT_W-1:0]   avoid_count;
  logic               turn_sign;

  function automatic void clear_scan_state();
    scan_pos  = 0;
    left_min  = RANGE_MAX;
    right_min = RANGE_MAX;
    front_hit = 1'b0;
    stop_hit  = 1'b0;
  endfunction

  // one sample into the scan state; the last sample of a scan queues its decision
  function automatic void track_sample(input logic [RANGE_W-1:0] range,
                                       input logic [RANGE_W-1:0] draw);
    int unsigned   n;
    int unsigned   quarter;
    avoid_result_t res;
    n = cfg.num_samples;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    quarter = n / 4;
    if (scan_pos > quarter && scan_pos < n - quarter && range < cfg.front_threshold_mm)
      front_hit = 1'b1;
    if (range < cfg.stop_threshold_mm) stop_hit = 1'b1;
    if (scan_pos > n / 2) begin
      if (range < left_min) left_min = range;
    end else if (range < right_min) begin
      right_min = range;
    end
    if (scan_pos + 1 < n) begin
      scan_pos++;
      return;
    end
    res.avoiding = front_hit || stop_hit || avoid_count != 0;
    res.new_turn = 1'b0;
    if (res.avoiding) begin
      if (avoid_count == 0) begin
        avoid_count  = CNT_W'(draw % AVOID_RUN + AVOID_RUN);
        turn_sign    = !(left_min < right_min);
        res.new_turn = 1'b1;
      end
      avoid_count = avoid_count - 1'b1;
    end
    res.stop_now      = stop_hit;
    res.turn_positive = turn_sign;
    res.min_left      = left_min;
    res.min_right     = right_min;
    expected_results.insert(expected_results.size(), res);
    clear_scan_state();
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    avoid_result_t exp_res;
    if (!rst_n) begin
      cfg.num_samples        = NUM_SAMPLES_RST;
      cfg.front_threshold_mm = FRONT_THR_RST;
      cfg.stop_threshold_mm  = STOP_THR_RST;
      clear_scan_state();
      avoid_count = '0;
      turn_sign   = 1'b0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_NUM_SAMPLES: cfg.num_samples        = pwdata[NS_W-1:0];
          REG_FRONT_THR:   cfg.front_threshold_mm = pwdata[RANGE_W-1:0];
          REG_STOP_THR:    cfg.stop_threshold_mm  = pwdata[RANGE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual avoiding %0b min %0d/%0d",
                   $time, out_avoiding, out_min_left_mm, out_min_right_mm);
        end else begin
          exp_res = expected_results[0];
          expected_results.delete(0);
          results_checked++;
          check_field("avoiding", exp_res.avoiding, out_avoiding);
          check_field("stop_now", exp_res.stop_now, out_stop_now);
          check_field("new_turn", exp_res.new_turn, out_new_turn);
          check_field("turn_positive", exp_res.turn_positive, out_turn_positive);
          check_field("min_left_mm", exp_res.min_left, out_min_left_mm);
          check_field("min_right_mm", exp_res.min_right, out_min_right_mm);
        end
      end
      if (in_valid && !in_stall) track_sample(in_range_mm, in_rand_draw);
    end
    pending_results <= expected_results.size();
  end

endmodule

@@ tb/sv/laser_scan_obstacle_avoid_top_tb.sv @@
// testbench top: drives laser samples and register writes, gives the verdict
module laser_scan_obstacle_avoid_top_tb
  import lsoa_pkg::*;
();

  localparam int         RANDOM_SAMPLES = 1000;
  localparam int         CALM_AFTER     = 880;   // random samples before idling stops
  localparam int         SETTLE_CYCLES  = 6;     // settling margin for a sample still in flight
  localparam logic [1:0] REG_SPARE      = 2'd3;  // unmapped register slot

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [RANGE_W-1:0] in_range_mm = '0;
  logic [RANGE_W-1:0] in_rand_draw = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_avoiding;
  logic               out_stop_now;
  logic               out_new_turn;
  logic               out_turn_positive;
  logic [RANGE_W-1:0] out_min_left_mm;
  logic [RANGE_W-1:0] out_min_right_mm;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int mismatches;
  int pending_results;
  int results_checked;

  // stimulus bookkeeping, kept to shape the samples and for the final report
  int          samples_sent = 0;
  int          reg_writes = 0;
  int          calm_from = 32'h7FFF_FFFF;  // sample count past which idling stops
  int unsigned scan_len = 360;
  int unsigned front_thr = 600;
  int unsigned stop_thr = 500;

  // idling controls: gaps on input, stall bursts on output, calm turns both off
  logic       gaps_on = 1'b0;
  logic       stall_on = 1'b0;
  logic       calm = 1'b0;
  logic [2:0] stall_left = '0;

  always #6 clk = ~clk;

  laser_scan_obstacle_avoid_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_range_mm       (in_range_mm),
    .in_rand_draw      (in_rand_draw),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_avoiding      (out_avoiding),
    .out_stop_now      (out_stop_now),
    .out_new_turn      (out_new_turn),
    .out_turn_positive (out_turn_positive),
    .out_min_left_mm   (out_min_left_mm),
    .out_min_right_mm  (out_min_right_mm),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  lsoa_scan_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_range_mm       (in_range_mm),
    .in_rand_draw      (in_rand_draw),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_avoiding      (out_avoiding),
    .out_stop_now      (out_stop_now),
    .out_new_turn      (out_new_turn),
    .out_turn_positive (out_turn_positive),
    .out_min_left_mm   (out_min_left_mm),
    .out_min_right_mm  (out_min_right_mm),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatches        (mismatches),
    .pending_results   (pending_results),
    .results_checked   (results_checked)
  );

  // result side back-pressure: random stall bursts
  always @(posedge clk) begin
    if (!rst_n || calm || !stall_on) begin
      out_stall  <= 1'b0;
      stall_left <= '0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= 3'($urandom_range(0, 3));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // scan length as the block sees it: zero acts as one, large values clip
  function automatic int unsigned eff_len(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_SAMPLES) return MAX_SAMPLES;
    return v;
  endfunction

  // ranges cluster at the extremes and right around both thresholds
  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RANGE_MAX;
      2, 3:    return RANGE_W'($urandom_range(0, 4000));
      4:       return RANGE_W'(front_thr + $urandom_range(0, 2) - 1);
      5:       return RANGE_W'(stop_thr + $urandom_range(0, 2) - 1);
      default: return RANGE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int unsigned pick_threshold();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  // apb write: setup cycle, access cycle, then back to idle
  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_NUM_SAMPLES: scan_len  = eff_len(value);
      REG_FRONT_THR:   front_thr = value;
      REG_STOP_THR:    stop_thr  = value;
      default: ;
    endcase
  endtask

  // one sample item, with an optional leading gap
  task automatic send_sample(input logic [RANGE_W-1:0] range, input logic [RANGE_W-1:0] draw);
    if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_range_mm  <= range;
    in_rand_draw <= draw;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (samples_sent > calm_from) calm <= 1'b1;
  endtask

  // drain: every predicted result out, then a settling margin for a sample still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int random_start;
    int scans;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: samples well short of a 360-sample scan give no result
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'd499, 16'hFFFF);   // just under the reset stop threshold
    send_sample(16'd500, 16'h5A5A);
    send_sample(16'd0, 16'hA5A5);
    send_sample(16'hFFFF, 16'h1234);
    send_sample(16'd1234, 16'h8001);
    wait_idle();

    // shrink the scan mid-way: the next sample ends it, stop seen, count loads ten
    write_reg(REG_NUM_SAMPLES, 4);
    send_sample(16'd700, 16'd65530);
    wait_idle();

    // unmapped slot must be ignored; zero scan length acts as one-sample scans
    write_reg(REG_SPARE, 0);
    write_reg(REG_FRONT_THR, 1000);
    write_reg(REG_STOP_THR, 200);
    write_reg(REG_NUM_SAMPLES, 0);
    // nine scans ride out the avoid count, the tenth is clear with an empty left half
    repeat (10) send_sample(16'hFFFF, RANGE_W'($urandom_range(0, 65535)));
    wait_idle();

    // four-sample scan: front window is index 2 only, left half index 3 only
    write_reg(REG_NUM_SAMPLES, 4);
    send_sample(16'd1000, 16'h0000);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'd999, 16'h0000);
    send_sample(16'd0, 16'hFFFF);
    wait_idle();

    // oversize scan length clips to the maximum; cut the scan short afterwards
    write_reg(REG_NUM_SAMPLES, 2047);
    send_sample(16'd0, 16'h0001);
    send_sample(16'hFFFF, 16'h0002);
    send_sample(16'd300, 16'h0003);
    wait_idle();
    write_reg(REG_NUM_SAMPLES, 4);
    send_sample(16'd5000, 16'h7FFF);
    wait_idle();

    // random phases: new settings, whole scans with random content, sometimes a
    // trailing partial scan that the next setting cuts off
    random_start = samples_sent;
    calm_from    = random_start + CALM_AFTER;
    while (samples_sent - random_start < RANDOM_SAMPLES) begin
      gaps_on  <= ($urandom_range(0, 3) != 0);
      stall_on <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 15))
          0:        write_reg(REG_NUM_SAMPLES, 0);
          1, 2:     write_reg(REG_NUM_SAMPLES, $urandom_range(9, 48));
          default:  write_reg(REG_NUM_SAMPLES, $urandom_range(1, 8));
        endcase
      end
      if ($urandom_range(0, 1) == 0) write_reg(REG_FRONT_THR, pick_threshold());
      if ($urandom_range(0, 1) == 0) write_reg(REG_STOP_THR, pick_threshold());
      scans = $urandom_range(1, 5);
      repeat (scans * scan_len) send_sample(pick_range(), RANGE_W'($urandom_range(0, 65535)));
      if ($urandom_range(0, 3) == 0 && scan_len > 1)
        repeat ($urandom_range(1, scan_len - 1))
          send_sample(pick_range(), RANGE_W'($urandom_range(0, 65535)));
      wait_idle();
    end

    $display("run covered %0d samples, %0d scan results checked, %0d register writes",
             samples_sent, results_checked, reg_writes);
    if (mismatches == 0 && pending_results == 0) begin
      $display("laser_scan_obstacle_avoid_top verification clean");
    end else begin
      $display("laser_scan_obstacle_avoid_top verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(12 * 500000);
    $display("laser_scan_obstacle_avoid_top verification failed");
    $finish;
  end

endmodule
